/* rtl/ksd_pkg.sv */
// Shared codes and field widths for the two-sample KS distance block.
// No dependencies; used by two_sample_ks_distance.
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

  // Fixed widths of the word fields
  localparam int unsigned KindW   = 2;
  localparam int unsigned SampleW = 32;
  localparam int unsigned GapW    = 21;
  localparam int unsigned CountW  = 11;
  localparam int unsigned StatusW = 2;

  // Input word kinds; the fourth code is ignored
  typedef enum logic [KindW-1:0] {
    KIND_APPEND_X = 2'd0,
    KIND_APPEND_Y = 2'd1,
    KIND_EVALUATE = 2'd2
  } kind_e;

  // Result status, highest priority last
  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_ORDER    = 2'd3
  } status_e;

endpackage : ksd_pkg

`default_nettype wire

/* rtl/two_sample_ks_distance.sv */
// Two-sample Kolmogorov-Smirnov distance: sample stores, load logic and merge walk.
// Depends on ksd_pkg for word kinds, status codes and field widths.
`timescale 1ns / 1ps
`default_nettype none

// Append words (kind 0 to set X, kind 1 to set Y) are taken one per cycle while
// idle and written into two sample memories of MAX_SAMPLES entries each, every
// memory with one write port and one read port. An evaluate word (kind 2) starts a
// merge walk over both memories that reads one entry of each per cycle; the
// next word is taken once the result word enters the output register, and the
// walk is skipped when either set is empty. The walk length is set by the one
// read port per memory. No word is taken during the walk, and a result word
// that still waits holds the walk in its last step until the output register
// frees. The result word is held in an output register, so appends may follow
// an evaluate while its result still waits. The evaluate clears both sets and
// the overflow and order flags. Kind 3 is taken and ignored.

module two_sample_ks_distance #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  // input channel
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire         [ksd_pkg::KindW-1:0]       kind_i,
  input  wire  signed [ksd_pkg::SampleW-1:0]     sample_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic        [ksd_pkg::GapW-1:0]        gap_numerator_o,
  output logic        [ksd_pkg::CountW-1:0]      count_x_o,
  output logic        [ksd_pkg::CountW-1:0]      count_y_o,
  output logic        [ksd_pkg::StatusW-1:0]     status_o
);

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BW = 2 * CW;
  localparam int unsigned DW = 2 * CW + 1;
  localparam int unsigned SW = SAMPLE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEST,
    ST_TX,
    ST_TY,
    ST_GUARD,
    ST_FINISH
  } state_e;

  // Sample memories and registered read data
  logic signed [SW-1:0] x_mem [MAX_SAMPLES];
  logic signed [SW-1:0] y_mem [MAX_SAMPLES];
  logic signed [SW-1:0] x_head_q, y_head_q;

  state_e               state_q, state_d;
  logic [CW-1:0]        x_fill_q, x_fill_d, y_fill_q, y_fill_d;
  logic                 ovf_q, ovf_d, order_q, order_d;
  logic signed [SW-1:0] x_last_q, x_last_d, y_last_q, y_last_d;
  logic [CW-1:0]        i_q, i_d, j_q, j_d;
  logic signed [SW-1:0] v_q, v_d;
  logic signed [DW-1:0] diff_q, diff_d;
  logic [BW-1:0]        best_q, best_d;
  logic                 out_valid_q, out_valid_d;
  logic [ksd_pkg::GapW-1:0]    gap_q, gap_d;
  logic [ksd_pkg::CountW-1:0]  cnt_x_q, cnt_x_d, cnt_y_q, cnt_y_d;
  logic [ksd_pkg::StatusW-1:0] status_q, status_d;

  logic                 in_fire;
  logic signed [SW-1:0] key;
  logic                 x_we, y_we;
  logic                 x_more, y_more;
  logic signed [DW-1:0] m_ext, n_ext, diff_abs;
  logic                 gx, gy;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign key        = SW'(sample_i);

  // Walk helpers: step sizes and head availability
  assign m_ext    = $signed(DW'(y_fill_q));
  assign n_ext    = $signed(DW'(x_fill_q));
  assign x_more   = (i_q < x_fill_q);
  assign y_more   = (j_q < y_fill_q);
  assign gx       = x_more && (x_head_q < v_q);
  assign gy       = y_more && (y_head_q < v_q);
  assign diff_abs = diff_q[DW-1] ? -diff_q : diff_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    x_fill_d    = x_fill_q;
    y_fill_d    = y_fill_q;
    ovf_d       = ovf_q;
    order_d     = order_q;
    x_last_d    = x_last_q;
    y_last_d    = y_last_q;
    i_d         = i_q;
    j_d         = j_q;
    v_d         = v_q;
    diff_d      = diff_q;
    best_d      = best_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    gap_d       = gap_q;
    cnt_x_d     = cnt_x_q;
    cnt_y_d     = cnt_y_q;
    status_d    = status_q;
    x_we        = 1'b0;
    y_we        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        if (in_fire) begin
          case (kind_i)
            ksd_pkg::KIND_APPEND_X: begin
              if (x_fill_q == CW'(MAX_SAMPLES)) begin
                ovf_d = 1'b1;
              end else begin
                x_we     = 1'b1;
                x_fill_d = x_fill_q + 1'b1;
                x_last_d = key;
                if ((x_fill_q != '0) && (key < x_last_q)) order_d = 1'b1;
              end
            end
            ksd_pkg::KIND_APPEND_Y: begin
              if (y_fill_q == CW'(MAX_SAMPLES)) begin
                ovf_d = 1'b1;
              end else begin
                y_we     = 1'b1;
                y_fill_d = y_fill_q + 1'b1;
                y_last_d = key;
                if ((y_fill_q != '0) && (key < y_last_q)) order_d = 1'b1;
              end
            end
            ksd_pkg::KIND_EVALUATE: begin
              diff_d = '0;
              best_d = '0;
              if ((x_fill_q == '0) || (y_fill_q == '0)) state_d = ST_FINISH;
              else                                       state_d = ST_BEST;
            end
            default: ;
          endcase
        end
      end

      // Fold the running gap into the maximum and pick the next group value
      ST_BEST: begin
        if (BW'(diff_abs) > best_q) best_d = BW'(diff_abs);
        if (x_more || y_more) begin
          if (x_more && y_more) v_d = (x_head_q < y_head_q) ? x_head_q : y_head_q;
          else if (x_more)      v_d = x_head_q;
          else                  v_d = y_head_q;
          state_d = ST_TX;
        end else begin
          state_d = ST_FINISH;
        end
      end

      // Take the X entries equal to the group value
      ST_TX: begin
        if (x_more && (x_head_q == v_q)) begin
          diff_d = diff_q + m_ext;
          i_d    = i_q + 1'b1;
        end else begin
          state_d = ST_TY;
        end
      end

      // Take the Y entries equal to the group value
      ST_TY: begin
        if (y_more && (y_head_q == v_q)) begin
          diff_d = diff_q - n_ext;
          j_d    = j_q + 1'b1;
        end else begin
          state_d = ST_GUARD;
        end
      end

      // Unsorted input: step past one smaller head on each side
      ST_GUARD: begin
        diff_d = diff_q + (gx ? m_ext : '0) - (gy ? n_ext : '0);
        if (gx) i_d = i_q + 1'b1;
        if (gy) j_d = j_q + 1'b1;
        state_d = ST_BEST;
      end

      // Hand the result word over and clear the sets
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          gap_d       = ksd_pkg::GapW'(best_q);
          cnt_x_d     = ksd_pkg::CountW'(x_fill_q);
          cnt_y_d     = ksd_pkg::CountW'(y_fill_q);
          if (order_q)                                status_d = ksd_pkg::STATUS_ORDER;
          else if (ovf_q)                             status_d = ksd_pkg::STATUS_OVERFLOW;
          else if ((x_fill_q == '0) || (y_fill_q == '0)) status_d = ksd_pkg::STATUS_EMPTY;
          else                                        status_d = ksd_pkg::STATUS_OK;
          x_fill_d = '0;
          y_fill_d = '0;
          ovf_d    = 1'b0;
          order_d  = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_fill_q    <= '0;
      y_fill_q    <= '0;
      ovf_q       <= 1'b0;
      order_q     <= 1'b0;
      x_last_q    <= '0;
      y_last_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      v_q         <= '0;
      diff_q      <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      gap_q       <= '0;
      cnt_x_q     <= '0;
      cnt_y_q     <= '0;
      status_q    <= ksd_pkg::STATUS_OK;
    end else begin
      state_q     <= state_d;
      x_fill_q    <= x_fill_d;
      y_fill_q    <= y_fill_d;
      ovf_q       <= ovf_d;
      order_q     <= order_d;
      x_last_q    <= x_last_d;
      y_last_q    <= y_last_d;
      i_q         <= i_d;
      j_q         <= j_d;
      v_q         <= v_d;
      diff_q      <= diff_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
      gap_q       <= gap_d;
      cnt_x_q     <= cnt_x_d;
      cnt_y_q     <= cnt_y_d;
      status_q    <= status_d;
    end
  end

  // X store: write at fill, read ahead at the next walk index
  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[x_fill_q[AW-1:0]] <= key;
    x_head_q <= x_mem[i_d[AW-1:0]];
  end

  // Y store
  always_ff @(posedge clk_i) begin
    if (y_we) y_mem[y_fill_q[AW-1:0]] <= key;
    y_head_q <= y_mem[j_d[AW-1:0]];
  end

  assign out_valid_o     = out_valid_q;
  assign gap_numerator_o = gap_q;
  assign count_x_o       = cnt_x_q;
  assign count_y_o       = cnt_y_q;
  assign status_o        = status_q;

endmodule : two_sample_ks_distance

`default_nettype wire
